FILE: src/esc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// esc_pkg: shared types and constants for the escaped packet deframer.
// No dependencies; imported by every module of the block.

package esc_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic REG_SYNC = 1'b0;
    localparam logic REG_ESC  = 1'b1;

    localparam logic [7:0] SYNC_RESET = 8'hFF;
    localparam logic [7:0] ESC_RESET  = 8'hFD;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] escape_value;
    } cfg_t;

    typedef struct packed {
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] byte_index;
        logic [7:0] value;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/esc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// esc_cfg_regs: APB register file holding the sync and escape byte values.
// Depends on esc_pkg.

module esc_cfg_regs
    import esc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    logic reg_sel;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value   <= SYNC_RESET;
            cfg_reg.escape_value <= ESC_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SYNC: cfg_reg.sync_value   <= pwdata[7:0];
                REG_ESC:  cfg_reg.escape_value <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_SYNC: prdata[7:0] = cfg_reg.sync_value;
            REG_ESC:  prdata[7:0] = cfg_reg.escape_value;
            default:  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/esc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// esc_in_stage: input register for raw bytes from the serial link.
// Depends on esc_pkg.

module esc_in_stage
    import esc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_raw_byte,
    input  wire logic       advance,
    output logic            step_valid,
    output logic      [7:0] step_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;

    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_valid || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_raw_byte;
        end
    end

    assign step_valid = in_valid_reg && advance;
    assign step_byte  = byte_reg;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg))
        else $error("stalled input byte lost or changed");

endmodule

`default_nettype wire

FILE: src/esc_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// esc_parser: sync hunt, unescape and packet field tracking, one byte per step.
// Depends on esc_pkg.

module esc_parser
    import esc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       step_valid,
    input  wire logic [7:0] step_byte,
    output logic            emit,
    output result_t         result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       pend_reg, pend_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] data_byte;
    logic       is_esc;

    assign is_esc    = (step_byte == cfg.escape_value);
    assign data_byte = pend_reg ? 8'(step_byte + 8'd1) : step_byte;

    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;

        result.command_code   = cmd_reg;
        result.payload_length = len_reg;
        result.byte_index     = cnt_reg;
        result.value          = data_byte;
        result.last           = (cnt_reg == len_reg);

        if (step_valid) begin
            if (phase_reg == PH_HUNT) begin
                phase_next = (step_byte == cfg.sync_value) ? PH_CMD : PH_HUNT;
            end else if (is_esc) begin
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
                unique case (phase_reg)
                    PH_CMD: begin
                        cmd_next   = data_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN: begin
                        len_next   = data_byte;
                        cnt_next   = 8'd0;
                        phase_next = PH_BODY;
                    end
                    PH_BODY: begin
                        emit = 1'b1;
                        if (cnt_reg != len_reg) begin
                            cnt_next = 8'(cnt_reg + 8'd1);
                        end else begin
                            phase_next = PH_HUNT;
                            cmd_next   = 8'd0;
                            len_next   = 8'd0;
                            cnt_next   = 8'd0;
                        end
                    end
                    default: phase_next = PH_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pend_reg  <= 1'b0;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.last |=> phase_reg == PH_HUNT && !pend_reg)
        else $error("packet end did not return to hunting");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> cnt_reg <= len_reg)
        else $error("body index past declared length");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !result.last |=> cnt_reg == 8'($past(cnt_reg) + 8'd1))
        else $error("body index did not advance");

endmodule

`default_nettype wire

FILE: src/esc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// esc_out_stage: result register toward the downstream channel.
// Depends on esc_pkg.

module esc_out_stage
    import esc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire result_t    result,
    output logic            can_take,
    output logic            m_valid,
    input  wire logic       m_ready,
    output result_t         m_result
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    assign can_take       = !out_valid_reg || m_ready;
    assign out_valid_next = load || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = res_reg;

endmodule

`default_nettype wire

FILE: src/escaped_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Escaped packet deframer. Takes one raw byte per cycle on s_raw_byte and
// emits one item per payload byte and one for the checksum (m_last set).
// Throughput is one byte per cycle while m_ready is high. m_valid rises once an
// accepted byte has moved from the input register through the combinational
// unescape and parse logic into the result register. Sync, command,
// length and escape bytes produce no item. sync_value (0x0) and escape_value
// (0x4) are written over APB and take effect on the next byte processed.
// Depends on esc_pkg, esc_cfg_regs, esc_in_stage, esc_parser, esc_out_stage.

module escaped_packet_deframer
    import esc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_raw_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_command_code,
    output logic      [7:0]         m_payload_length,
    output logic      [7:0]         m_byte_index,
    output logic      [7:0]         m_value,
    output logic                    m_last
);

    cfg_t       cfg;
    logic       advance;
    logic       step_valid;
    logic [7:0] step_byte;
    logic       emit;
    result_t    result;
    result_t    m_result;

    esc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_raw_byte (s_raw_byte),
        .advance    (advance),
        .step_valid (step_valid),
        .step_byte  (step_byte)
    );

    esc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step_valid (step_valid),
        .step_byte  (step_byte),
        .emit       (emit),
        .result     (result)
    );

    esc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit),
        .result   (result),
        .can_take (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_command_code   = m_result.command_code;
    assign m_payload_length = m_result.payload_length;
    assign m_byte_index     = m_result.byte_index;
    assign m_value          = m_result.value;
    assign m_last           = m_result.last;

endmodule

`default_nettype wire
